### sv/phk_pkg.sv
// Package for the perfect-hash key lookup block.
// Holds the table geometry, function and address codes, the item type and state enums.
// Has no dependencies; phk_front, phk_back and the top level import it.
`default_nettype none

package phk_pkg;

  localparam int unsigned LgTableSize = 5;
  localparam int unsigned TableSize   = 1 << LgTableSize;
  localparam int unsigned KeyWords    = 4;
  localparam int unsigned WordW       = 64;
  localparam int unsigned MultW       = 32;
  localparam int unsigned SlotW       = LgTableSize;
  localparam int unsigned FoundW      = LgTableSize + 1;

  localparam logic [MultW-1:0] HashMultReset = 32'd650148382;

  // Function codes of an input item.
  localparam logic [1:0] FuncKeyWr = 2'd0;
  localparam logic [1:0] FuncValWr = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  // Word index that closes a query.
  localparam logic [1:0] LastWord = 2'd3;

  // Configuration register word addresses (paddr[2]).
  localparam logic AddrHashMult = 1'b0;

  typedef enum logic [1:0] {
    OpKeyWr,
    OpValWr,
    OpQword,
    OpLookup
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [1:0]       word;
    logic [WordW-1:0] data;
  } item_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkCompare
  } back_state_e;

endpackage

`default_nettype wire

### sv/phk_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the key and value stores of the lookup block.
`default_nettype none

module phk_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/phk_front.sv
// Front part of the lookup block: accepts input items, classifies them and queues them.
// Depends on phk_pkg for the function codes and the queued item type.
`default_nettype none

module phk_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [4:0]            slot_index_i,
  input  wire logic [1:0]            word_index_i,
  input  wire logic [63:0]           data_word_i,
  output logic                       q_valid_o,
  output phk_pkg::item_t             q_item_o,
  input  wire logic                  q_pop_i
);
  import phk_pkg::*;

  localparam int unsigned Depth = 2;

  item_t       entry_q [Depth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       item;
  logic        accept;
  logic        push;

  assign in_stall_o = (count_q == 2'(Depth));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item.slot = slot_index_i[SlotW-1:0];
    item.word = word_index_i;
    item.data = data_word_i;
    item.op   = OpKeyWr;
    push      = accept;
    case (func_i)
      FuncKeyWr: item.op = OpKeyWr;
      FuncValWr: item.op = OpValWr;
      FuncQuery: item.op = (word_index_i == LastWord) ? OpLookup : OpQword;
      default:   push    = 1'b0;  // Unknown function: taken and dropped.
    endcase
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

### sv/phk_back.sv
// Back part of the lookup block: table writes, query word latching, hashing and key compare.
// Depends on phk_pkg and instantiates phk_ram for the four key-word stores and the value store.
`default_nettype none

module phk_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [phk_pkg::MultW-1:0]  hash_mult_i,
  input  wire logic                       q_valid_i,
  input  wire phk_pkg::item_t             q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            hit_o,
  output logic [5:0]                      found_slot_o,
  output logic [63:0]                     found_value_o
);
  import phk_pkg::*;

  back_state_e state_q, state_d;

  logic [WordW-1:0]       qw_q [3];
  logic [WordW-1:0]       last_q;
  logic [SlotW-1:0]       h_q, h_d;
  logic [MultW-1:0]       prod;

  logic [KeyWords-1:0][TableSize-1:0] kvld_q;
  logic [TableSize-1:0]               vvld_q;

  logic [WordW-1:0]       key_rd [KeyWords];
  logic [WordW-1:0]       val_rd;
  logic                   rd_en;
  logic                   pop;
  logic                   load_out;
  logic                   out_free;
  logic                   hit;
  logic [KeyWords-1:0]    word_eq;
  logic [WordW-1:0]       stored_val;

  assign out_free = !out_valid_o || !out_stall_i;
  assign prod     = hash_mult_i * qw_q[1][MultW-1:0];
  assign h_d      = prod[MultW-1 -: SlotW];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (q_valid_i && q_item_i.op == OpLookup) begin
          state_d = BkRead;
        end
      end
      BkRead:    state_d = BkCompare;
      BkCompare: begin
        if (out_free) begin
          state_d = BkIdle;
        end
      end
      default:   state_d = BkIdle;
    endcase
  end

  // State outputs.
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BkIdle:    pop      = q_valid_i;
      BkRead:    rd_en    = 1'b1;
      BkCompare: load_out = out_free;
      default:   pop      = 1'b0;
    endcase
  end

  assign q_pop_o = pop;

  for (genvar i = 0; i < KeyWords; i++) begin : g_key
    phk_ram #(
      .Width (WordW),
      .Depth (TableSize)
    ) u_key_ram (
      .clk_i   (clk_i),
      .we_i    (pop && q_item_i.op == OpKeyWr && q_item_i.word == 2'(i)),
      .waddr_i (q_item_i.slot),
      .wdata_i (q_item_i.data),
      .re_i    (rd_en),
      .raddr_i (h_q),
      .rdata_o (key_rd[i])
    );
  end

  phk_ram #(
    .Width (WordW),
    .Depth (TableSize)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (pop && q_item_i.op == OpValWr),
    .waddr_i (q_item_i.slot),
    .wdata_i (q_item_i.data),
    .re_i    (rd_en),
    .raddr_i (h_q),
    .rdata_o (val_rd)
  );

  // An entry that was never written since reset reads as zero.
  always_comb begin
    word_eq[0] = (kvld_q[0][h_q] ? key_rd[0] : '0) == qw_q[0];
    word_eq[1] = (kvld_q[1][h_q] ? key_rd[1] : '0) == qw_q[1];
    word_eq[2] = (kvld_q[2][h_q] ? key_rd[2] : '0) == qw_q[2];
    word_eq[3] = (kvld_q[3][h_q] ? key_rd[3] : '0) == last_q;
    hit        = &word_eq;
    stored_val = vvld_q[h_q] ? val_rd : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      kvld_q      <= '0;
      vvld_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop && q_item_i.op == OpKeyWr) begin
        kvld_q[q_item_i.word][q_item_i.slot] <= 1'b1;
      end
      if (pop && q_item_i.op == OpValWr) begin
        vvld_q[q_item_i.slot] <= 1'b1;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_item_i.op == OpQword) begin
      case (q_item_i.word)
        2'd0:    qw_q[0] <= q_item_i.data;
        2'd1:    qw_q[1] <= q_item_i.data;
        default: qw_q[2] <= q_item_i.data;
      endcase
    end
    if (pop && q_item_i.op == OpLookup) begin
      h_q    <= h_d;
      last_q <= q_item_i.data;
    end
    if (load_out) begin
      hit_o         <= hit;
      found_slot_o  <= hit ? {1'b0, h_q} : 6'(TableSize);
      found_value_o <= hit ? stored_val : '0;
    end
  end

endmodule

`default_nettype wire

### sv/perfect_hash_key_lookup.sv
// Top level of the perfect-hash key lookup block: configuration port, front and back parts.
// Depends on phk_pkg, phk_front, phk_back (and through it phk_ram).
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o func_i, slot_index_i, word_index_i, data_word_i
//   out      output     out_valid_o/out_stall_i hit_o, found_slot_o, found_value_o
//   config   input      APB psel/penable/pready paddr, pwdata, prdata
//
// A two-entry queue parts the front from the back. The back retires a write or a
// query word as it pops it; a lookup holds it through the hash multiply, the table
// read and the key compare, after which the result waits in the output register.
// Reset clears the per-entry valid bits of the key and value stores at once; no
// clearing pass is needed. A stalled output holds the back, which then fills the queue.
`default_nettype none

module perfect_hash_key_lookup (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [4:0]  slot_index_i,
  input  wire logic [1:0]  word_index_i,
  input  wire logic [63:0] data_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_o,
  output logic [5:0]       found_slot_o,
  output logic [63:0]      found_value_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import phk_pkg::*;

  logic [MultW-1:0] hash_mult_q;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrHashMult) ? hash_mult_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mult_q <= HashMultReset;
    end else if (psel && penable && pwrite && paddr[2] == AddrHashMult) begin
      hash_mult_q <= pwdata;
    end
  end

  phk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .slot_index_i (slot_index_i),
    .word_index_i (word_index_i),
    .data_word_i  (data_word_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  phk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hash_mult_i   (hash_mult_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .found_slot_o  (found_slot_o),
    .found_value_o (found_value_o)
  );

endmodule

`default_nettype wire
